/* hdl/brat_pkg.sv */
// ----------------------------------------------------------------------------
// brat_pkg
// Shared widths, register indexes and reset values for the bounded rational
// approximation block.
// ----------------------------------------------------------------------------
package brat_pkg;

  // field widths
  localparam int FRAC_BITS  = 32;
  localparam int DENOM_BITS = 16;
  localparam int INT_BITS   = 15;
  localparam int TOL_BITS   = 32;
  localparam int NUM_BITS   = 32;

  // search datapath widths
  localparam int BD_W  = DENOM_BITS + 1;           // a, b, c, d
  localparam int SUM_W = DENOM_BITS + 2;           // mediant numerator and denominator
  localparam int PRD_W = FRAC_BITS + SUM_W;        // f*b, f*d, tol*b, tol*d and sums
  localparam int MAG_W = INT_BITS + DENOM_BITS + 1; // rn + ip*rd

  // stream payload widths
  localparam int IN_DATA_W  = ((1 + INT_BITS + FRAC_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NUM_BITS + DENOM_BITS + 7) / 8) * 8;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TOL_BITS;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DENOM = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'd1;

  localparam logic [DENOM_BITS-1:0] MAX_DENOM_RST = DENOM_BITS'(1000);
  localparam logic [TOL_BITS-1:0]   TOLERANCE_RST = TOL_BITS'(4295);

  // numerator magnitude limit
  localparam logic [63:0] NUM_SAT = 64'd2147483647;

endpackage

/* hdl/bounded_rational_approximation.sv */
// ----------------------------------------------------------------------------
// bounded_rational_approximation
// Best rational approximation num/den of a signed fixed-point value with den
// bounded by a register, found by a Stern-Brocot mediant search.
// ----------------------------------------------------------------------------
//
//  channel  | direction | transaction contents
//  ---------+-----------+------------------------------------------------------
//  in_      | slave     | tdata: x_negative, x_integer[14:0], x_fraction[31:0]
//  out_     | master    | tdata: numerator[31:0] (signed), denominator[15:0]
//  cfg_     | write     | index 0 max_denominator, index 1 tolerance
//
//  one item is loaded in ST_IDLE, then takes one mediant step per cycle (at most about
//  2*max_denominator steps, typically far fewer); the last step picks the result,
//  then ST_MUL and ST_SUM rebuild the numerator, ST_SUM waiting while the output
//  register is full; the mediant step loop sets how long an item takes
//  products f*(b+d) and tol*(b+d) are kept as running sums, no multiplier in
//  the loop; the final ip*den uses one 15x16 multiplier
//  in_tready is high only while idle; a waiting result in the output register
//  does not block a new transaction, but a finished search waits for it
//  synchronous active-low reset clears control state and the configuration registers
//
module bounded_rational_approximation (
  input  logic                                clk,
  input  logic                                rst_n,
  // x_negative [0], x_integer [15:1], x_fraction [47:16]
  input  logic [brat_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // numerator [31:0], denominator [47:32]
  output logic [brat_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [brat_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [brat_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int DW = brat_pkg::DENOM_BITS;
  localparam int BW = brat_pkg::BD_W;
  localparam int SW = brat_pkg::SUM_W;
  localparam int PW = brat_pkg::PRD_W;
  localparam int FW = brat_pkg::FRAC_BITS;
  localparam int IW = brat_pkg::INT_BITS;
  localparam int MW = brat_pkg::MAG_W;
  localparam int NW = brat_pkg::NUM_BITS;
  localparam int TW = brat_pkg::TOL_BITS;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_MUL    = 2'd2;
  localparam logic [1:0] ST_SUM    = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [DW-1:0] max_denom_r;
  logic [TW-1:0] tol_cfg_r;

  // per-item operands
  logic          neg_r, neg_nxt;
  logic [IW-1:0] ip_r, ip_nxt;
  logic [DW-1:0] lim_r, lim_nxt;

  // search state
  logic [BW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [SW-1:0] s_r, s_nxt, num_r, num_nxt;
  logic [PW-1:0] fb_r, fb_nxt, fd_r, fd_nxt, tb_r, tb_nxt, td_r, td_nxt;
  logic [PW-1:0] lhs_r, lhs_nxt, ts_r, ts_nxt;

  // result
  logic [DW-1:0]    rn_r, rn_nxt, rd_r, rd_nxt;
  logic [IW+DW-1:0] prod_r, prod_nxt;
  logic [NW+DW-1:0] out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;

  // datapath signals
  logic [PW-1:0] rhs, diff_hi, diff_lo, diff;
  logic          lhs_gt, match, in_range;
  logic [MW-1:0] mag_sum;
  logic [NW-1:0] mag, num_out;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = brat_pkg::OUT_DATA_W'(out_data_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_denom_r <= brat_pkg::MAX_DENOM_RST;
      tol_cfg_r   <= brat_pkg::TOLERANCE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        brat_pkg::REG_MAX_DENOM: max_denom_r <= cfg_data[DW-1:0];
        brat_pkg::REG_TOLERANCE: tol_cfg_r   <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // mediant compare: |f*s - (a+c)*2^FRAC| against tol*s
  always_comb begin
    rhs      = {num_r, {FW{1'b0}}};
    lhs_gt   = (lhs_r > rhs);
    diff_hi  = lhs_r - rhs;
    diff_lo  = rhs - lhs_r;
    diff     = lhs_gt ? diff_hi : diff_lo;
    match    = (diff < ts_r);
    in_range = (b_r <= BW'(lim_r)) && (d_r <= BW'(lim_r));
  end

  // numerator rebuild, saturation and sign
  always_comb begin
    mag_sum = MW'(rn_r) + MW'(prod_r);
    if (64'(mag_sum) > brat_pkg::NUM_SAT) begin
      mag = NW'(brat_pkg::NUM_SAT);
    end else begin
      mag = NW'(mag_sum);
    end
    num_out = neg_r ? (NW'(0) - mag) : mag;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    neg_nxt       = neg_r;
    ip_nxt        = ip_r;
    lim_nxt       = lim_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    s_nxt         = s_r;
    num_nxt       = num_r;
    fb_nxt        = fb_r;
    fd_nxt        = fd_r;
    tb_nxt        = tb_r;
    td_nxt        = td_r;
    lhs_nxt       = lhs_r;
    ts_nxt        = ts_r;
    rn_nxt        = rn_r;
    rd_nxt        = rd_r;
    prod_nxt      = prod_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    // result taken downstream
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      // load bounds 0/1 and 1/1
      ST_IDLE: begin
        if (in_tvalid) begin
          neg_nxt = in_tdata[0];
          ip_nxt  = in_tdata[IW:1];
          lim_nxt = (max_denom_r == '0) ? DW'(1) : max_denom_r;
          a_nxt   = '0;
          b_nxt   = BW'(1);
          c_nxt   = BW'(1);
          d_nxt   = BW'(1);
          s_nxt   = SW'(2);
          num_nxt = SW'(1);
          fb_nxt  = PW'(in_tdata[IW+FW:IW+1]);
          fd_nxt  = PW'(in_tdata[IW+FW:IW+1]);
          tb_nxt  = PW'(tol_cfg_r);
          td_nxt  = PW'(tol_cfg_r);
          lhs_nxt = PW'({in_tdata[IW+FW:IW+1], 1'b0});
          ts_nxt  = PW'({tol_cfg_r, 1'b0});
          state_nxt = ST_SEARCH;
        end
      end

      // one mediant step per cycle
      ST_SEARCH: begin
        if (!in_range) begin
          if (b_r > BW'(lim_r)) begin
            rn_nxt = DW'(c_r);
            rd_nxt = DW'(d_r);
          end else begin
            rn_nxt = DW'(a_r);
            rd_nxt = DW'(b_r);
          end
          state_nxt = ST_MUL;
        end else if (match) begin
          if (s_r <= SW'(lim_r)) begin
            rn_nxt = DW'(num_r);
            rd_nxt = DW'(s_r);
          end else if (d_r > b_r) begin
            rn_nxt = DW'(c_r);
            rd_nxt = DW'(d_r);
          end else begin
            rn_nxt = DW'(a_r);
            rd_nxt = DW'(b_r);
          end
          state_nxt = ST_MUL;
        end else if (lhs_gt) begin
          // lower bound moves up to the mediant
          a_nxt   = BW'(num_r);
          b_nxt   = BW'(s_r);
          fb_nxt  = lhs_r;
          tb_nxt  = ts_r;
          s_nxt   = s_r + SW'(d_r);
          num_nxt = num_r + SW'(c_r);
          lhs_nxt = lhs_r + fd_r;
          ts_nxt  = ts_r + td_r;
        end else begin
          // upper bound moves down to the mediant
          c_nxt   = BW'(num_r);
          d_nxt   = BW'(s_r);
          fd_nxt  = lhs_r;
          td_nxt  = ts_r;
          s_nxt   = s_r + SW'(b_r);
          num_nxt = num_r + SW'(a_r);
          lhs_nxt = lhs_r + fb_r;
          ts_nxt  = ts_r + tb_r;
        end
      end

      // integer part times denominator
      ST_MUL: begin
        prod_nxt  = (IW+DW)'(ip_r) * (IW+DW)'(rd_r);
        state_nxt = ST_SUM;
      end

      // add back, sign, hand to output register when free
      ST_SUM: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {rd_r, num_out};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    ip_r       <= ip_nxt;
    lim_r      <= lim_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    s_r        <= s_nxt;
    num_r      <= num_nxt;
    fb_r       <= fb_nxt;
    fd_r       <= fd_nxt;
    tb_r       <= tb_nxt;
    td_r       <= td_nxt;
    lhs_r      <= lhs_nxt;
    ts_r       <= ts_nxt;
    rn_r       <= rn_nxt;
    rd_r       <= rd_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* tb/bounded_rational_approximation_checker.sv */
// ----------------------------------------------------------------------------
// bounded_rational_approximation_checker
// Watches the input, result and register-write ports of the rational
// approximation block, predicts each fraction with its own mediant search and
// compares every result transaction field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module bounded_rational_approximation_checker
  import brat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    error_count,
  output int                    results_pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [NUM_BITS-1:0] num;
    logic [DENOM_BITS-1:0]      den;
  } fraction_t;

  // shadow copies of the two registers
  logic [DENOM_BITS-1:0] denom_limit;
  logic [TOL_BITS-1:0]   match_tol;

  fraction_t expected_fractions[$];

  // stern-brocot search between 0/1 and 1/1, then integer part and sign
  function automatic fraction_t best_fraction(input logic neg,
                                              input logic [INT_BITS-1:0] ip,
                                              input logic [FRAC_BITS-1:0] frac,
                                              input logic [DENOM_BITS-1:0] limit_reg,
                                              input logic [TOL_BITS-1:0] tol_reg);
    logic [63:0] lim, tol, f, lo_n, lo_d, hi_n, hi_d;
    logic [63:0] sum_d, lhs, rhs, diff, res_n, res_d, mag;
    bit found;
    fraction_t r;
    lim = (limit_reg == '0) ? 64'd1 : 64'(limit_reg);
    tol = 64'(tol_reg);
    f = 64'(frac);
    lo_n = 0; lo_d = 1; hi_n = 1; hi_d = 1;
    res_n = 0; res_d = 1;
    found = 1'b0;
    while (lo_d <= lim && hi_d <= lim && !found) begin
      sum_d = lo_d + hi_d;
      lhs = f * sum_d;
      rhs = (lo_n + hi_n) << FRAC_BITS;
      diff = (lhs > rhs) ? lhs - rhs : rhs - lhs;
      if (diff < tol * sum_d) begin
        found = 1'b1;
        // mediant if it fits, else the bound with the larger denominator
        if (sum_d <= lim) begin
          res_n = lo_n + hi_n;
          res_d = sum_d;
        end else if (hi_d > lo_d) begin
          res_n = hi_n;
          res_d = hi_d;
        end else begin
          res_n = lo_n;
          res_d = lo_d;
        end
      end else if (lhs > rhs) begin
        lo_n = lo_n + hi_n;
        lo_d = sum_d;
      end else begin
        hi_n = hi_n + lo_n;
        hi_d = sum_d;
      end
    end
    // a bound ran past the limit: take the other one
    if (!found) begin
      if (lo_d > lim) begin
        res_n = hi_n;
        res_d = hi_d;
      end else begin
        res_n = lo_n;
        res_d = lo_d;
      end
    end
    mag = res_n + 64'(ip) * res_d;
    if (mag > NUM_SAT) begin
      mag = NUM_SAT;
    end
    if (neg) begin
      mag = 64'd0 - mag;
    end
    r.num = mag[NUM_BITS-1:0];
    r.den = res_d[DENOM_BITS-1:0];
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // track register writes, predict on input transactions, check results
  always @(posedge clk) begin
    fraction_t got, want;
    if (!rst_n) begin
      denom_limit = MAX_DENOM_RST;
      match_tol = TOLERANCE_RST;
      expected_fractions.delete();
      error_count = 0;
      results_pending <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MAX_DENOM: denom_limit = cfg_data[DENOM_BITS-1:0];
          REG_TOLERANCE: match_tol = cfg_data[TOL_BITS-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        expected_fractions.push_back(best_fraction(in_tdata[0],
                                                   in_tdata[INT_BITS:1],
                                                   in_tdata[INT_BITS+FRAC_BITS:INT_BITS+1],
                                                   denom_limit, match_tol));
      end
      if (out_tvalid && out_tready) begin
        got.num = out_tdata[NUM_BITS-1:0];
        got.den = out_tdata[NUM_BITS+DENOM_BITS-1:NUM_BITS];
        if (expected_fractions.size() == 0) begin
          log_mismatch($sformatf("unexpected result %0d/%0d", got.num, got.den));
        end else begin
          want = expected_fractions.pop_front();
          if (got.num !== want.num || got.den !== want.den) begin
            log_mismatch($sformatf("numerator exp %0d got %0d, denominator exp %0d got %0d",
                                   want.num, got.num, want.den, got.den));
          end
        end
      end
      results_pending <= expected_fractions.size();
    end
  end

endmodule

/* tb/bounded_rational_approximation_test.sv */
// ----------------------------------------------------------------------------
// bounded_rational_approximation_test
// Drives directed and random fixed-point values through the rational
// approximation block over a range of denominator limits and tolerances, with
// bursty input, a patterned result stall and one long hold-off; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module bounded_rational_approximation_test;

  timeunit 1ns;
  timeprecision 1ps;

  import brat_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;

  typedef enum {READY_ALWAYS, READY_COIN, READY_MOSTLY, READY_RARELY} ready_mode_e;
  typedef enum {FRAC_RANDOM, FRAC_RATIO, FRAC_NEAR_RATIO, FRAC_TINY, FRAC_NEAR_ONE,
                FRAC_EXTREME} frac_kind_e;

  logic clk = 1'b0;
  logic rst_n;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   error_count;
  int   results_pending;
  int   cycle_count = 0;
  int   burst_left = 0;
  logic hold_req;

  always #5 clk = ~clk;

  bounded_rational_approximation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  bounded_rational_approximation_checker approx_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .results_pending (results_pending)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: segments of random stall patterns plus one long hold-off
  initial begin
    ready_mode_e mode;
    int seg_left;
    int hold_left;
    bit hold_done;
    mode = READY_ALWAYS;
    seg_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = 600;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = ready_mode_e'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (mode)
          READY_ALWAYS: out_tready <= 1'b1;
          READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
          READY_MOSTLY: out_tready <= ($urandom_range(0, 7) != 0);
          default:      out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // one input transaction, with bursts separated by random gaps
  task automatic send_item(input logic neg, input logic [INT_BITS-1:0] ip,
                           input logic [FRAC_BITS-1:0] frac);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tdata <= IN_DATA_W'({frac, ip, neg});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // write both registers on consecutive cycles
  task automatic configure(input logic [DENOM_BITS-1:0] denom, input logic [TOL_BITS-1:0] tol);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_MAX_DENOM;
    cfg_data <= CFG_DATA_W'(denom);
    @(posedge clk);
    cfg_index <= REG_TOLERANCE;
    cfg_data <= CFG_DATA_W'(tol);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one register setting followed by random values
  task automatic run_phase(input int denom, input logic [TOL_BITS-1:0] tol, input int count);
    frac_kind_e kind;
    int cap, q, p;
    logic [63:0] ratio;
    logic [FRAC_BITS-1:0] frac;
    logic [INT_BITS-1:0] ip;
    wait_results_done();
    configure(DENOM_BITS'(denom), tol);
    cap = (denom * 2 < 2) ? 2 : ((denom * 2 > 65535) ? 65535 : denom * 2);
    for (int i = 0; i < count; i++) begin
      // long searches at large limits only for ordinary values
      if (denom > 4096) begin
        kind = frac_kind_e'($urandom_range(0, 2));
      end else begin
        kind = frac_kind_e'($urandom_range(0, 5));
      end
      q = $urandom_range(1, cap);
      p = $urandom_range(0, q - 1);
      ratio = (64'(p) << FRAC_BITS) / 64'(q);
      case (kind)
        FRAC_RANDOM:     frac = $urandom();
        FRAC_RATIO:      frac = ratio[FRAC_BITS-1:0];
        FRAC_NEAR_RATIO: frac = ratio[FRAC_BITS-1:0] + $urandom_range(0, 8191) - 4096;
        FRAC_TINY:       frac = $urandom_range(0, 255);
        FRAC_NEAR_ONE:   frac = 32'hFFFF_FFFF - $urandom_range(0, 255);
        default: begin
          case ($urandom_range(0, 2))
            0: frac = '0;
            1: frac = '1;
            default: frac = 32'h8000_0000;
          endcase
        end
      endcase
      case ($urandom_range(0, 5))
        0: ip = '0;
        1: ip = '1;
        2: ip = INT_BITS'($urandom_range(0, 9));
        default: ip = INT_BITS'($urandom());
      endcase
      send_item(1'($urandom_range(0, 1)), ip, frac);
    end
  endtask

  // main sequence
  initial begin
    rst_n <= 1'b0;
    in_tdata <= '0;
    in_tvalid <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_MAX_DENOM;
    cfg_data <= '0;
    hold_req <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed values at the reset settings
    send_item(1'b0, 15'd0, 32'h0000_0000);
    send_item(1'b1, 15'd0, 32'h0000_0000);      // negative zero
    send_item(1'b0, 15'h7FFF, 32'hFFFF_FFFF);
    send_item(1'b1, 15'h7FFF, 32'hFFFF_FFFF);
    send_item(1'b0, 15'd5, 32'h0000_0000);      // integer only
    send_item(1'b0, 15'd0, 32'h8000_0000);
    send_item(1'b0, 15'd0, 32'h5555_5555);
    send_item(1'b1, 15'd3, 32'h243F_6A88);
    send_item(1'b0, 15'd0, 32'h0000_0001);
    send_item(1'b0, 15'd0, 32'hFFFF_FFFE);
    send_item(1'b1, 15'd1, 32'h4000_0000);
    send_item(1'b0, 15'h5555, 32'hAAAA_AAAA);
    send_item(1'b1, 15'h2AAA, 32'h5555_5555);
    send_item(1'b0, 15'd7, 32'h1999_999A);

    // zero tolerance: exact values never match
    wait_results_done();
    configure(16'd1000, 32'd0);
    send_item(1'b0, 15'd0, 32'h8000_0000);
    send_item(1'b1, 15'd2, 32'h0000_0000);
    send_item(1'b0, 15'd0, 32'hC000_0000);

    // smallest limit with widest tolerance
    wait_results_done();
    configure(16'd1, 32'hFFFF_FFFF);
    send_item(1'b0, 15'd4, 32'h7FFF_FFFF);
    send_item(1'b1, 15'd0, 32'hFFFF_FFFF);

    // zero limit acts as one
    wait_results_done();
    configure(16'd0, 32'd4295);
    send_item(1'b0, 15'd9, 32'h9000_0000);
    send_item(1'b1, 15'd0, 32'h3000_0000);

    // random phases; the first one includes the long result hold-off
    wait_results_done();
    hold_req <= 1'b1;
    run_phase(1000, 32'd4295, 90);
    run_phase(1, $urandom(), 30);
    run_phase(2, 32'd0, 30);
    run_phase($urandom_range(3, 64), $urandom_range(0, 1 << 20), 80);
    run_phase($urandom_range(65, 400), 32'd0, 70);
    run_phase(255, 32'hFFFF_FFFF, 30);
    run_phase(0, $urandom(), 15);
    run_phase($urandom_range(1, 200), $urandom(), 80);
    run_phase(65535, 32'd0, 6);
    run_phase(65535, 32'd4295, 6);
    run_phase($urandom_range(1, 1000), $urandom_range(0, 1 << 16), 120);

    wait_results_done();
    repeat (50) @(posedge clk);
    if (error_count == 0 && results_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/brat_pkg.sv
hdl/bounded_rational_approximation.sv
tb/bounded_rational_approximation_checker.sv
tb/bounded_rational_approximation_test.sv
